// ----- src/i2cmbe_pkg.sv -----
package i2cmbe_pkg;

  localparam int DELAY_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int IN_BITS    = 16;
  localparam int OUT_BITS   = 16;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_STOP  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic CFG_BIT_HOLD = 1'b0;
  localparam logic CFG_EDGE_GAP = 1'b1;

  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [7:0] LSB_ONE  = 8'h01;

  typedef logic [DELAY_BITS-1:0] delay_t;

  typedef struct packed {
    logic       sda_level;
    logic       ack_after_read;
    logic [7:0] write_data;
    logic       cmd_valid;
  } in_word_t;

  typedef struct packed {
    logic       ack_seen;
    logic [7:0] read_data;
    logic       done_res;
    logic       ready_res;
    logic       sda_drive_low;
    logic       scl_drive_low;
  } out_word_t;

endpackage

// ----- src/i2c_master_byte_engine_core.sv -----
// the result word is registered; a skid register takes one more word while m_tready is low
// throughput: one word per cycle, until the skid register is full and s_tready goes low
// rate is set by the single state update between the input handshake and the output register
// reset: synchronous, active high; bus lines released, state idle, both delays set to 5
module i2c_master_byte_engine_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [i2cmbe_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // cmd_valid, write_data[7:0], ack_after_read, sda_level, zero fill
  input  logic [i2cmbe_pkg::IN_BITS-1:0]  s_tdata,
  // func[1:0]
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // scl_drive_low, sda_drive_low, ready_res, done_res, read_data[7:0], ack_seen, zero fill
  output logic [i2cmbe_pkg::OUT_BITS-1:0] m_tdata
);
  import i2cmbe_pkg::*;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_START_A = 4'd1;
  localparam logic [3:0] PH_START_B = 4'd2;
  localparam logic [3:0] PH_STOP_A  = 4'd3;
  localparam logic [3:0] PH_STOP_B  = 4'd4;
  localparam logic [3:0] PH_WR_LOW  = 4'd5;
  localparam logic [3:0] PH_WR_HIGH = 4'd6;
  localparam logic [3:0] PH_RD_LOW  = 4'd7;
  localparam logic [3:0] PH_RD_HIGH = 4'd8;
  localparam logic [3:0] PH_RA_LOW  = 4'd9;
  localparam logic [3:0] PH_RA_HIGH = 4'd10;

  localparam logic [3:0] LAST_BIT = 4'd8;

  delay_t     bit_hold;
  delay_t     edge_gap;
  logic [3:0] phase, phase_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  delay_t     tick_count, tick_count_next;
  logic       scl_low, scl_low_next;
  logic       sda_low, sda_low_next;
  logic       ack_reg, ack_reg_next;
  logic [7:0] read_reg, read_reg_next;
  logic       ack_plan, ack_plan_next;
  logic       done;

  logic       out_valid, skid_valid;
  logic [OUT_BITS-1:0] out_data, skid_data, res_data;

  in_word_t   in_word;
  out_word_t  res;
  logic       accept, drain;
  delay_t     wait_len;
  logic [DELAY_BITS:0] count_inc;
  logic       wait_end;
  logic [3:0] bit_inc;
  logic [7:0] shift_left, shift_in;

  assign in_word  = in_word_t'(s_tdata[$bits(in_word_t)-1:0]);
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign drain    = out_valid && m_tready;

  always_comb begin
    if (phase == PH_START_A || phase == PH_START_B || phase == PH_STOP_A
        || phase == PH_STOP_B) begin
      wait_len = edge_gap;
    end else begin
      wait_len = bit_hold;
    end
    if (wait_len == '0) begin
      wait_len = delay_t'(1);
    end
  end

  assign count_inc  = {1'b0, tick_count} + {{DELAY_BITS{1'b0}}, 1'b1};
  assign wait_end   = count_inc >= {1'b0, wait_len};
  assign bit_inc    = bit_index + 4'd1;
  assign shift_left = {shift_byte[6:0], 1'b0};
  assign shift_in   = shift_left | (in_word.sda_level ? LSB_ONE : 8'h00);

  always_comb begin
    phase_next      = phase;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    scl_low_next    = scl_low;
    sda_low_next    = sda_low;
    ack_reg_next    = ack_reg;
    read_reg_next   = read_reg;
    ack_plan_next   = ack_plan;
    done            = 1'b0;
    tick_count_next = wait_end ? '0 : count_inc[DELAY_BITS-1:0];
    unique case (phase)
      PH_IDLE: begin
        tick_count_next = tick_count;
        if (in_word.cmd_valid) begin
          tick_count_next = '0;
          unique case (s_tuser)
            FUNC_START: begin
              scl_low_next = 1'b0;
              sda_low_next = 1'b0;
              phase_next   = PH_START_A;
            end
            FUNC_STOP: begin
              sda_low_next = 1'b1;
              phase_next   = PH_STOP_A;
            end
            FUNC_WRITE: begin
              shift_byte_next = in_word.write_data;
              bit_index_next  = '0;
              scl_low_next    = 1'b1;
              sda_low_next    = (in_word.write_data & MSB_MASK) == 8'h00;
              phase_next      = PH_WR_LOW;
            end
            FUNC_READ: begin
              shift_byte_next = '0;
              bit_index_next  = '0;
              ack_plan_next   = in_word.ack_after_read;
              scl_low_next    = 1'b1;
              sda_low_next    = 1'b0;
              phase_next      = PH_RD_LOW;
            end
          endcase
        end
      end
      PH_START_A: begin
        if (wait_end) begin
          sda_low_next = 1'b1;
          phase_next   = PH_START_B;
        end
      end
      PH_START_B: begin
        if (wait_end) begin
          scl_low_next = 1'b1;
          done         = 1'b1;
          phase_next   = PH_IDLE;
        end
      end
      PH_STOP_A: begin
        if (wait_end) begin
          scl_low_next = 1'b0;
          phase_next   = PH_STOP_B;
        end
      end
      PH_STOP_B: begin
        if (wait_end) begin
          sda_low_next = 1'b0;
          done         = 1'b1;
          phase_next   = PH_IDLE;
        end
      end
      PH_WR_LOW, PH_RD_LOW, PH_RA_LOW: begin
        if (wait_end) begin
          scl_low_next = 1'b0;
          phase_next   = phase + 4'd1;
        end
      end
      PH_WR_HIGH: begin
        if (wait_end) begin
          scl_low_next = 1'b1;
          if (bit_index >= LAST_BIT) begin
            ack_reg_next   = !in_word.sda_level;
            sda_low_next   = !in_word.sda_level;
            bit_index_next = '0;
            done           = 1'b1;
            phase_next     = PH_IDLE;
          end else begin
            bit_index_next = bit_inc;
            if (bit_inc < LAST_BIT) begin
              shift_byte_next = shift_left;
              sda_low_next    = (shift_left & MSB_MASK) == 8'h00;
            end else begin
              sda_low_next = 1'b0;
            end
            phase_next = PH_WR_LOW;
          end
        end
      end
      PH_RD_HIGH: begin
        if (wait_end) begin
          shift_byte_next = shift_in;
          scl_low_next    = 1'b1;
          bit_index_next  = bit_inc;
          if (bit_inc >= LAST_BIT) begin
            read_reg_next = shift_in;
            sda_low_next  = ack_plan;
            phase_next    = PH_RA_LOW;
          end else begin
            phase_next = PH_RD_LOW;
          end
        end
      end
      PH_RA_HIGH: begin
        if (wait_end) begin
          scl_low_next   = 1'b1;
          bit_index_next = '0;
          done           = 1'b1;
          phase_next     = PH_IDLE;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase
  end

  always_comb begin
    res.scl_drive_low = scl_low_next;
    res.sda_drive_low = sda_low_next;
    res.ready_res     = phase_next == PH_IDLE;
    res.done_res      = done;
    res.read_data     = read_reg_next;
    res.ack_seen      = ack_reg_next;
    res_data          = OUT_BITS'(res);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_hold <= delay_t'(5);
      edge_gap <= delay_t'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BIT_HOLD: bit_hold <= cfg_data[DELAY_BITS-1:0];
        CFG_EDGE_GAP: edge_gap <= cfg_data[DELAY_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_index  <= '0;
      shift_byte <= '0;
      tick_count <= '0;
      scl_low    <= 1'b0;
      sda_low    <= 1'b0;
      ack_reg    <= 1'b0;
      read_reg   <= '0;
      ack_plan   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      tick_count <= tick_count_next;
      scl_low    <= scl_low_next;
      sda_low    <= sda_low_next;
      ack_reg    <= ack_reg_next;
      read_reg   <= read_reg_next;
      ack_plan   <= ack_plan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!out_valid || drain) begin
        out_data  <= res_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res_data;
        skid_valid <= 1'b1;
      end
    end else if (drain) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
